### design/sha_pkg.sv
// SHA-256 hasher package: beat types, front-to-back queue entry, constants.
// Used by every module of the sha256_message_hasher_core block.
package sha_pkg;

  typedef struct packed {
    logic [31:0] message_word;
    logic [2:0]  valid_bytes;
    logic        last_word;
  } in_beat_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_result;
  } out_beat_t;

  // Classified word for the back end: data word, end-of-block, end-of-message
  typedef struct packed {
    logic [31:0] word;
    logic        blk_end;
    logic        msg_end;
  } blk_word_t;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QAw = 2;

  localparam logic [31:0] PadWord = 32'h80000000;

  localparam logic [31:0] HashInit [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  function automatic logic [31:0] ror(input logic [31:0] x, input int unsigned n);
    ror = (x >> n) | (x << (32 - n));
  endfunction

endpackage

### design/sha_front.sv
// SHA-256 front end: accepts message beats, pads, appends the bit length.
// Emits one classified block word per cycle while the queue has room; depends on sha_pkg.
module sha_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  sha_pkg::in_beat_t  in_data,
  output logic               q_valid,
  input  logic               q_full,
  output sha_pkg::blk_word_t q_data
);

  typedef enum logic [4:0] {
    S_MSG   = 5'b00001,
    S_PAD80 = 5'b00010,
    S_ZERO  = 5'b00100,
    S_LENHI = 5'b01000,
    S_LENLO = 5'b10000
  } fst_t;

  fst_t        st_r, st_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [63:0] len_r, len_nxt;
  logic [2:0]  nb;
  logic [31:0] keep, padw;
  logic        acc, push;

  assign acc      = in_valid && !in_stall;
  assign push     = q_valid && !q_full;
  assign in_stall = (st_r != S_MSG) || q_full;
  assign nb       = (in_data.valid_bytes > 3'd4) ? 3'd4 : in_data.valid_bytes;

  // Build the last word: mask its valid bytes and add the 0x80 marker if partial
  always_comb begin
    case (nb)
      3'd0:    begin keep = 32'h0;        padw = 32'h80000000; end
      3'd1:    begin keep = 32'hff000000; padw = 32'h00800000; end
      3'd2:    begin keep = 32'hffff0000; padw = 32'h00008000; end
      3'd3:    begin keep = 32'hffffff00; padw = 32'h00000080; end
      default: begin keep = 32'hffffffff; padw = 32'h0;        end
    endcase
  end

  // Select the word and next state; go straight to the length at word 14
  always_comb begin
    st_nxt  = st_r;
    cnt_nxt = cnt_r;
    len_nxt = len_r;
    q_valid = 1'b0;
    q_data  = '0;
    case (st_r)
      S_MSG: begin
        q_valid = in_valid;
        if (!in_data.last_word) begin
          q_data.word = in_data.message_word;
        end else begin
          q_data.word = (in_data.message_word & keep) | padw;
        end
        if (acc) begin
          if (!in_data.last_word) begin
            len_nxt = len_r + 64'd32;
          end else begin
            len_nxt = len_r + {58'd0, nb, 3'd0};
            if (nb == 3'd4) st_nxt = S_PAD80;
            else if (cnt_r == 4'd13) st_nxt = S_LENHI;
            else st_nxt = S_ZERO;
          end
        end
      end
      S_PAD80: begin
        q_valid     = 1'b1;
        q_data.word = sha_pkg::PadWord;
        if (push) st_nxt = (cnt_r == 4'd13) ? S_LENHI : S_ZERO;
      end
      S_ZERO: begin
        q_valid     = 1'b1;
        q_data.word = 32'h0;
        if (push && cnt_r == 4'd13) st_nxt = S_LENHI;
      end
      S_LENHI: begin
        q_valid     = 1'b1;
        q_data.word = len_r[63:32];
        if (push) st_nxt = S_LENLO;
      end
      S_LENLO: begin
        q_valid        = 1'b1;
        q_data.word    = len_r[31:0];
        q_data.msg_end = 1'b1;
        if (push) begin
          st_nxt  = S_MSG;
          len_nxt = '0;
        end
      end
      default: st_nxt = S_MSG;
    endcase
    q_data.blk_end = (cnt_r == 4'd15);
    if (push) cnt_nxt = cnt_r + 4'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= S_MSG;
      cnt_r <= '0;
      len_r <= '0;
    end else begin
      st_r  <= st_nxt;
      cnt_r <= cnt_nxt;
      len_r <= len_nxt;
    end
  end

  // Length words always land at block positions 14 and 15
  a_lenhi: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_LENHI && push) |-> cnt_r == 4'd14) else $error("length misplaced");
  a_end: assert property (@(posedge clk) disable iff (!rst_n)
    (push && q_data.msg_end) |-> q_data.blk_end) else $error("message end off block");
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != S_MSG) |-> in_stall) else $error("input taken while padding");

endmodule

### design/sha_queue.sv
// Short FIFO between front end and compression back end.
// Depends on sha_pkg for the entry type and depth.
module sha_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_valid,
  output logic               full,
  input  sha_pkg::blk_word_t wr_data,
  output logic               rd_valid,
  input  logic               rd_take,
  output sha_pkg::blk_word_t rd_data
);

  sha_pkg::blk_word_t mem_r [sha_pkg::QDepth];
  logic [sha_pkg::QAw-1:0] wp_r, rp_r;
  logic [sha_pkg::QAw:0]   cnt_r;
  logic wr, rd;

  assign full     = (cnt_r == (sha_pkg::QAw+1)'(sha_pkg::QDepth));
  assign rd_valid = (cnt_r != '0);
  assign wr       = wr_valid && !full;
  assign rd       = rd_take && rd_valid;
  assign rd_data  = mem_r[rp_r];

  // Store and advance pointers
  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wr_data;
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr) wp_r <= wp_r + 1'b1;
      if (rd) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + {{sha_pkg::QAw{1'b0}}, wr} - {{sha_pkg::QAw{1'b0}}, rd};
    end
  end

  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (sha_pkg::QAw+1)'(sha_pkg::QDepth)) else $error("queue overflow");
  a_rdv: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) |-> !rd) else $error("queue underflow");
  a_inc: assert property (@(posedge clk) disable iff (!rst_n)
    (wr && !rd) |=> cnt_r == $past(cnt_r) + 1'b1) else $error("count slip");

endmodule

### design/sha_back.sv
// SHA-256 back end: block buffer, 64-round compression, digest output.
// One round per cycle, schedule in a 16-word shift window; depends on sha_pkg.
module sha_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  output logic                q_take,
  input  sha_pkg::blk_word_t  q_data,
  output logic                out_valid,
  input  logic                out_stall,
  output sha_pkg::out_beat_t  out_data
);

  typedef enum logic [3:0] {
    B_LOAD = 4'b0001,
    B_RND  = 4'b0010,
    B_ADD  = 4'b0100,
    B_OUT  = 4'b1000
  } bst_t;

  bst_t        st_r, st_nxt;
  logic [31:0] w_r [16];
  logic [31:0] h_r [8];
  logic [31:0] v_r [8];
  logic [3:0]  wi_r;
  logic [5:0]  rnd_r;
  logic [2:0]  oi_r;
  logic        fin_r;
  logic [31:0] s0, s1, wnew, b1, ch, t1, b0, mj, wcur;

  assign q_take = (st_r == B_LOAD) && q_valid;
  assign wcur   = w_r[0];

  // Round datapath and schedule expansion
  always_comb begin
    s0   = sha_pkg::ror(w_r[1], 7) ^ sha_pkg::ror(w_r[1], 18) ^ (w_r[1] >> 3);
    s1   = sha_pkg::ror(w_r[14], 17) ^ sha_pkg::ror(w_r[14], 19) ^ (w_r[14] >> 10);
    wnew = w_r[0] + s0 + w_r[9] + s1;
    b1   = sha_pkg::ror(v_r[4], 6) ^ sha_pkg::ror(v_r[4], 11) ^ sha_pkg::ror(v_r[4], 25);
    ch   = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
    t1   = v_r[7] + b1 + ch + sha_pkg::RoundK[rnd_r] + wcur;
    b0   = sha_pkg::ror(v_r[0], 2) ^ sha_pkg::ror(v_r[0], 13) ^ sha_pkg::ror(v_r[0], 22);
    mj   = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
  end

  assign out_valid            = (st_r == B_OUT);
  assign out_data.digest_word = h_r[oi_r];
  assign out_data.word_index  = oi_r;
  assign out_data.last_result = (oi_r == 3'd7);

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      B_LOAD:  if (q_take && q_data.blk_end) st_nxt = B_RND;
      B_RND:   if (rnd_r == 6'd63) st_nxt = B_ADD;
      B_ADD:   st_nxt = fin_r ? B_OUT : B_LOAD;
      B_OUT:   if (!out_stall && oi_r == 3'd7) st_nxt = B_LOAD;
      default: st_nxt = B_LOAD;
    endcase
  end

  // Payload: block window, message-end flag, working variables
  always_ff @(posedge clk) begin
    if (q_take) begin
      w_r[wi_r] <= q_data.word;
      fin_r     <= q_data.msg_end;
    end
    if (st_r == B_LOAD && st_nxt == B_RND) begin
      for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
    end
    if (st_r == B_RND) begin
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
      w_r[15] <= wnew;
      v_r[7] <= v_r[6];
      v_r[6] <= v_r[5];
      v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2];
      v_r[2] <= v_r[1];
      v_r[1] <= v_r[0];
      v_r[0] <= t1 + b0 + mj;
    end
  end

  // Control and hash state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= B_LOAD;
      wi_r  <= '0;
      rnd_r <= '0;
      oi_r  <= '0;
      for (int i = 0; i < 8; i++) h_r[i] <= sha_pkg::HashInit[i];
    end else begin
      st_r <= st_nxt;
      if (q_take) wi_r <= wi_r + 4'd1;
      if (st_r == B_RND) rnd_r <= rnd_r + 6'd1;
      if (st_r == B_ADD) begin
        for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + v_r[i];
      end
      if (st_r == B_OUT && !out_stall) begin
        oi_r <= oi_r + 3'd1;
        if (oi_r == 3'd7) begin
          for (int i = 0; i < 8; i++) h_r[i] <= sha_pkg::HashInit[i];
        end
      end
    end
  end

  a_wi: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == B_RND) |-> wi_r == 4'd0) else $error("block not aligned");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == B_OUT && out_stall) |=> st_r == B_OUT && $stable(oi_r)) else $error("output slip");
  a_rnd: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != B_RND) |-> rnd_r == 6'd0) else $error("round count");

endmodule

### design/sha256_message_hasher_core.sv
// SHA-256 message hasher top: front end, queue, compression back end.
// Depends on sha_pkg, sha_front, sha_queue, sha_back.
//
// Usage: stream the message as big-endian 32-bit words on in_valid/in_stall
// with in_data; mark the final word with last_word and its valid_bytes
// (0..4, values above 4 count as 4). An empty message is one last word with
// valid_bytes 0. After the final word the block pads, appends the 64-bit bit
// length and emits eight digest beats on out_valid/out_stall, word_index 0..7,
// last_result on the eighth. It then restarts with the initial hash state.
// Operation: the back end runs one SHA-256 round per cycle. Each block is
// loaded word by word, compressed in 64 rounds and added into the hash.
// A four-entry queue lets the front end take words while a block
// compresses. Padding adds one word per cycle after the last word while the
// queue has room; the digest follows in the cycle after the last block's add.
// Reset (rst_n low, synchronous) loads the initial hash and empties the queue.
// A stalled output holds its beat; the block takes no new message words once
// the queue fills.
module sha256_message_hasher_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  sha_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output sha_pkg::out_beat_t out_data
);

  logic               fq_valid, fq_full, bq_valid, bq_take;
  sha_pkg::blk_word_t fq_data, bq_data;

  sha_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_data,
    .q_valid(fq_valid), .q_full(fq_full), .q_data(fq_data));

  sha_queue u_queue (
    .clk, .rst_n, .wr_valid(fq_valid), .full(fq_full), .wr_data(fq_data),
    .rd_valid(bq_valid), .rd_take(bq_take), .rd_data(bq_data));

  sha_back u_back (
    .clk, .rst_n, .q_valid(bq_valid), .q_take(bq_take), .q_data(bq_data),
    .out_valid, .out_stall, .out_data);

endmodule

### sim/sha256_message_hasher_core_test.sv
// Testbench for sha256_message_hasher_core: streams messages, predicts digests.
// Depends on sha_pkg and the sha256_message_hasher_core RTL.
module sha256_message_hasher_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 400000;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  sha_pkg::in_beat_t  in_data;
  logic               out_valid;
  logic               out_stall;
  sha_pkg::out_beat_t out_data;

  sha256_message_hasher_core i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // Predictor state
  logic [31:0] hv [8];
  logic [31:0] blk [16];
  int unsigned blk_cnt;
  logic [63:0] bit_len;
  sha_pkg::out_beat_t digest_q [$];

  // Stimulus words and directed expectations (first digest word, 0 = none)
  sha_pkg::in_beat_t stim_q [$];
  logic [31:0] ref_first [$];

  int unsigned err_cnt;
  int unsigned cyc;
  bit          stim_done;
  bit          hold_off;

  localparam logic [31:0] H0 [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [31:0] KTab [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  function automatic logic [31:0] rotr(logic [31:0] x, int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // Fold the 16-word block into the running hash
  task automatic fold_block();
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
    for (int i = 0; i < 16; i++) w[i] = blk[i];
    for (int i = 16; i < 64; i++)
      w[i] = w[i-16] + w[i-7]
           + (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3))
           + (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10));
    a = hv[0]; b = hv[1]; c = hv[2]; d = hv[3];
    e = hv[4]; f = hv[5]; g = hv[6]; h = hv[7];
    for (int i = 0; i < 64; i++) begin
      t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
         + KTab[i] + w[i];
      t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
    end
    hv[0] += a; hv[1] += b; hv[2] += c; hv[3] += d;
    hv[4] += e; hv[5] += f; hv[6] += g; hv[7] += h;
  endtask

  task automatic append_word(logic [31:0] w);
    blk[blk_cnt] = w;
    blk_cnt = (blk_cnt + 1) % 16;
    if (blk_cnt == 0) fold_block();
  endtask

  function automatic void hasher_reset();
    for (int i = 0; i < 8; i++) hv[i] = H0[i];
    blk_cnt = 0;
    bit_len = '0;
  endfunction

  // Advance the predictor by one accepted beat; queue digest words on last
  task automatic predict_beat(sha_pkg::in_beat_t bt);
    int unsigned nb;
    logic [31:0] keep;
    sha_pkg::out_beat_t ob;
    if (!bt.last_word) begin
      append_word(bt.message_word);
      bit_len += 32;
      return;
    end
    nb = (bt.valid_bytes > 4) ? 4 : bt.valid_bytes;
    bit_len += nb * 8;
    if (nb == 4) begin
      append_word(bt.message_word);
      append_word(sha_pkg::PadWord);
    end else begin
      keep = (nb == 0) ? 32'h0 : (32'hffffffff << (8 * (4 - nb)));
      append_word((bt.message_word & keep) | (32'h80 << (8 * (3 - nb))));
    end
    if (blk_cnt > 14) while (blk_cnt != 0) append_word(32'h0);
    while (blk_cnt < 14) append_word(32'h0);
    append_word(bit_len[63:32]);
    append_word(bit_len[31:0]);
    for (int i = 0; i < 8; i++) begin
      ob.digest_word = hv[i];
      ob.word_index = 3'(i);
      ob.last_result = (i == 7);
      digest_q.push_back(ob);
    end
    hasher_reset();
  endtask

  function automatic sha_pkg::in_beat_t mk(logic [31:0] w, logic [2:0] n, logic l);
    sha_pkg::in_beat_t b;
    b.message_word = w; b.valid_bytes = n; b.last_word = l;
    return b;
  endfunction

  // Queue a random message of len full words plus a final word
  function automatic void add_msg(int unsigned len);
    for (int i = 0; i < len; i++)
      stim_q.push_back(mk($urandom, 3'($urandom_range(0, 7)), 1'b0));
    stim_q.push_back(mk($urandom, 3'($urandom_range(0, 7)), 1'b1));
    ref_first.push_back(32'h0);
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Directed table: empty message, "abc", extremes, block-boundary padding
  initial begin
    // empty message: known digest e3b0c442...
    stim_q.push_back(mk(32'h0, 3'd0, 1'b1));        ref_first.push_back(32'he3b0c442);
    // "abc" in one partial word: ba7816bf...
    stim_q.push_back(mk(32'h616263ff, 3'd3, 1'b1)); ref_first.push_back(32'hba7816bf);
    stim_q.push_back(mk(32'hffffffff, 3'd7, 1'b1)); ref_first.push_back(32'h0);
    stim_q.push_back(mk(32'hffffffff, 3'd1, 1'b1)); ref_first.push_back(32'h0);
    stim_q.push_back(mk(32'h12345678, 3'd2, 1'b1)); ref_first.push_back(32'h0);
    // partial word that is not last counts as four bytes
    stim_q.push_back(mk(32'h00000000, 3'd1, 1'b0));
    stim_q.push_back(mk(32'hffffffff, 3'd4, 1'b1)); ref_first.push_back(32'h0);
    // 13, 14 and 15 full words give messages of one or two blocks after padding
    add_msg(13); add_msg(14); add_msg(15);
  end

  int unsigned n_sent;

  // Sender: walk the table, then random messages, in bursts with gaps
  initial begin
    int unsigned burst, gap, len;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    stim_done = 1'b0;
    err_cnt = 0;
    n_sent = 0;
    hasher_reset();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // random part: mostly short messages, a few long ones
    while (stim_q.size() < 200) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 40) : $urandom_range(0, 17);
      add_msg(len);
    end
    burst = $urandom_range(1, 12);
    while (stim_q.size() != 0) begin
      if (burst == 0) begin
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 10);
        if (gap != 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst = $urandom_range(1, 20);
      end
      in_valid <= 1'b1;
      in_data <= stim_q[0];
      @(posedge clk);
      while (in_stall) @(posedge clk);
      if (stim_q[0].last_word) begin
        predict_beat(stim_q[0]);
        if (ref_first[0] != 32'h0 && digest_q[digest_q.size()-8].digest_word
            != ref_first[0]) begin
          $display("%0t: known digest mismatch expected %h actual %h", $realtime,
                   ref_first[0], digest_q[digest_q.size()-8].digest_word);
          err_cnt++;
        end
        void'(ref_first.pop_front());
      end else begin
        predict_beat(stim_q[0]);
      end
      void'(stim_q.pop_front());
      n_sent++;
      burst--;
    end
    in_valid <= 1'b0;
    stim_done = 1'b1;
  end

  // Long receiver hold-off once, after the first 40 beats are sent
  initial begin
    hold_off = 1'b0;
    wait (n_sent >= 40);
    hold_off = 1'b1;
    repeat (600) @(posedge clk);
    hold_off = 1'b0;
  end

  // Receiver stall pattern
  initial begin
    int unsigned phase;
    out_stall = 1'b1;
    phase = 0;
    @(posedge rst_n);
    forever begin
      phase++;
      if (hold_off) out_stall <= 1'b1;
      else if ((phase / 64) % 3 == 0) out_stall <= 1'b0;
      else out_stall <= ($urandom_range(0, 3) == 0);
      @(posedge clk);
    end
  end

  // Compare each accepted digest beat with the oldest prediction
  always @(posedge clk) begin
    sha_pkg::out_beat_t ex;
    if (rst_n && out_valid && !out_stall) begin
      if (digest_q.size() == 0) begin
        $display("%0t: unexpected beat actual %h", $realtime, out_data);
        err_cnt++;
      end else begin
        ex = digest_q.pop_front();
        if (out_data.digest_word !== ex.digest_word) begin
          $display("%0t: digest_word expected %h actual %h", $realtime,
                   ex.digest_word, out_data.digest_word);
          err_cnt++;
        end
        if (out_data.word_index !== ex.word_index) begin
          $display("%0t: word_index expected %0d actual %0d", $realtime,
                   ex.word_index, out_data.word_index);
          err_cnt++;
        end
        if (out_data.last_result !== ex.last_result) begin
          $display("%0t: last_result expected %b actual %b", $realtime,
                   ex.last_result, out_data.last_result);
          err_cnt++;
        end
      end
    end
  end

  // End of run and timeout
  initial begin
    cyc = 0;
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc >= CycleLimit) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
      if (stim_done && digest_q.size() == 0) begin
        repeat (200) @(posedge clk);
        if (err_cnt == 0) $display("Testbench completed without errors");
        else $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

endmodule
